// File: rtl/core/hsec_pkg.sv
// Package for the Hamming single-error-correcting encode/correct block.
// Holds widths, reset values, register codes, status structs and the
// elaboration-time position helpers. No dependencies.
package hsec_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int DATA_W_DEF    = 32;
    localparam int MAX_CHECK_DEF = 6;

    // Lengths and syndromes fit in six bits for every legal sizing.
    localparam int LEN_W = 6;

    // Width of the check-count register and its reset value.
    localparam int              CHK_W       = 3;
    localparam logic [CHK_W-1:0] CHECK_RESET = 3'd3;

    // Fixed stored length when byte padding is selected.
    localparam int PAD_LEN = 8;

    // Configuration write port sizing.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_BITS  = 1'b0,
        CFG_PAD_TO_BYTE = 1'b1
    } cfg_index_t;

    // Status passed from the encoder to the decoder.
    typedef struct packed {
        logic [LEN_W-1:0] code_len;
        logic             len_over;
    } enc_stat_t;

    // Status produced by the decoder.
    typedef struct packed {
        logic [LEN_W-1:0] syndrome;
        logic             range_error;
    } dec_stat_t;

    // True when p is a power of two.
    function automatic bit is_pow2(input int p);
        return (p > 0) && ((p & (p - 1)) == 0);
    endfunction

    // Data slot held by a non-power-of-two position p (1-based).
    function automatic int pos_slot(input int p);
        int cnt;
        cnt = 0;
        for (int q = 1; q < p; q++) begin
            if (!is_pow2(q)) begin
                cnt++;
            end
        end
        return cnt;
    endfunction

    // Codeword position (1-based) that holds data slot s.
    function automatic int slot_pos(input int s);
        int cnt;
        int pos;
        cnt = 0;
        pos = 0;
        for (int q = 1; q < 256; q++) begin
            if (!is_pow2(q)) begin
                if (cnt == s && pos == 0) begin
                    pos = q;
                end
                cnt++;
            end
        end
        return pos;
    endfunction

    // Positions (bit p-1 for position p) whose number has bit i set.
    function automatic logic [63:0] cover_mask(input int i);
        logic [63:0] m;
        m = '0;
        for (int q = 1; q <= 64; q++) begin
            if (((q >> i) & 1) != 0) begin
                m[q-1] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/core/hsec_encode.sv
// Hamming encoder: places data bits, computes parity and trims the word
// to the stored length. Depends on hsec_pkg.
module hsec_encode #(
    parameter int DATA_W    = hsec_pkg::DATA_W_DEF,
    parameter int MAX_CHECK = hsec_pkg::MAX_CHECK_DEF,
    localparam int CW_W     = DATA_W + MAX_CHECK
) (
    input  logic [DATA_W-1:0]          data_word,
    input  logic [hsec_pkg::CHK_W-1:0] check_cnt,
    input  logic                       pad_to_byte,
    output logic [CW_W-1:0]            codeword,
    output hsec_pkg::enc_stat_t        stat
);

    localparam int LEN_W = hsec_pkg::LEN_W;

    logic [DATA_W-1:0] top_one;
    logic [LEN_W-1:0]  data_len;
    logic [LEN_W-1:0]  full_len;
    logic [LEN_W-1:0]  code_len;
    logic [CW_W-1:0]   data_at;
    logic [CW_W-1:0]   full_word;
    logic [CW_W-1:0]   len_mask;

    // Highest set bit of the data word, one-hot.
    for (genvar i = 0; i < DATA_W; i++) begin : g_top
        if (i == DATA_W - 1) begin : g_msb
            assign top_one[i] = data_word[i];
        end else begin : g_low
            assign top_one[i] = data_word[i] & ~(|data_word[DATA_W-1:i+1]);
        end
    end

    // Bit length of the data word from the one-hot top bit.
    always_comb begin
        data_len = '0;
        for (int i = 0; i < DATA_W; i++) begin
            data_len = data_len | ({LEN_W{top_one[i]}} & LEN_W'(i + 1));
        end
    end

    // Full code length and the stored length.
    assign full_len = data_len + LEN_W'(check_cnt);
    assign code_len = pad_to_byte ? LEN_W'(hsec_pkg::PAD_LEN) : full_len;

    // Data bits in the non-power-of-two positions up to the full length.
    for (genvar p = 1; p <= CW_W; p++) begin : g_place
        localparam int SLOT = hsec_pkg::pos_slot(p);
        if (hsec_pkg::is_pow2(p) || SLOT >= DATA_W) begin : g_none
            assign data_at[p-1] = 1'b0;
        end else begin : g_data
            assign data_at[p-1] = data_word[SLOT] & (LEN_W'(p) <= full_len);
        end
    end

    // Parity bits at power-of-two positions, data bits elsewhere.
    for (genvar p = 1; p <= CW_W; p++) begin : g_full
        if (hsec_pkg::is_pow2(p) && $clog2(p) < MAX_CHECK) begin : g_par
            localparam int            IDX = $clog2(p);
            localparam logic [CW_W-1:0] COV = CW_W'(hsec_pkg::cover_mask(IDX));
            assign full_word[p-1] = (hsec_pkg::CHK_W'(IDX) < check_cnt)
                                  & (LEN_W'(p) <= full_len)
                                  & (^(data_at & COV));
        end else begin : g_dat
            assign full_word[p-1] = data_at[p-1];
        end
    end

    // Keep only the stored positions.
    for (genvar p = 1; p <= CW_W; p++) begin : g_mask
        assign len_mask[p-1] = (LEN_W'(p) <= code_len);
    end

    assign codeword       = full_word & len_mask;
    assign stat.code_len  = code_len;
    assign stat.len_over  = (full_len > code_len);

endmodule

// File: rtl/core/hsec_decode.sv
// Hamming decoder: applies the flip mask, computes the syndrome, corrects a
// single error and extracts the data bits. Depends on hsec_pkg.
module hsec_decode #(
    parameter int DATA_W    = hsec_pkg::DATA_W_DEF,
    parameter int MAX_CHECK = hsec_pkg::MAX_CHECK_DEF,
    localparam int CW_W     = DATA_W + MAX_CHECK
) (
    input  logic [CW_W-1:0]            codeword,
    input  logic [CW_W-1:0]            flip_mask,
    input  logic [hsec_pkg::CHK_W-1:0] check_cnt,
    input  hsec_pkg::enc_stat_t        enc_stat,
    output hsec_pkg::dec_stat_t        stat,
    output logic [DATA_W-1:0]          corrected_data
);

    localparam int LEN_W = hsec_pkg::LEN_W;

    logic [CW_W-1:0]  len_mask;
    logic [CW_W-1:0]  rx_word;
    logic [CW_W-1:0]  fixed_word;
    logic [LEN_W-1:0] syndrome;
    logic             range_error;
    logic             do_fix;

    // Injected errors only land in stored positions.
    for (genvar p = 1; p <= CW_W; p++) begin : g_mask
        assign len_mask[p-1] = (LEN_W'(p) <= enc_stat.code_len);
    end

    assign rx_word = codeword ^ (flip_mask & len_mask);

    // One parity check per enabled check bit.
    for (genvar i = 0; i < LEN_W; i++) begin : g_syn
        if (i < MAX_CHECK) begin : g_chk
            localparam logic [CW_W-1:0] COV = CW_W'(hsec_pkg::cover_mask(i));
            assign syndrome[i] = (hsec_pkg::CHK_W'(i) < check_cnt) & (^(rx_word & COV));
        end else begin : g_zero
            assign syndrome[i] = 1'b0;
        end
    end

    // Correction is suppressed when the length or syndrome is out of range.
    assign range_error = enc_stat.len_over || (syndrome > enc_stat.code_len);
    assign do_fix      = !range_error && (syndrome != '0);

    for (genvar p = 1; p <= CW_W; p++) begin : g_fix
        assign fixed_word[p-1] = rx_word[p-1] ^ (do_fix && (syndrome == LEN_W'(p)));
    end

    // Data slots read back from their positions; positions past the
    // stored length are already zero.
    for (genvar s = 0; s < DATA_W; s++) begin : g_extract
        localparam int POS = hsec_pkg::slot_pos(s);
        if (POS <= CW_W) begin : g_bit
            assign corrected_data[s] = fixed_word[POS-1];
        end else begin : g_none
            assign corrected_data[s] = 1'b0;
        end
    end

    assign stat.syndrome    = syndrome;
    assign stat.range_error = range_error;

endmodule

// File: rtl/core/hamming_sec_encode_correct.sv
// Top level of the Hamming single-error-correcting encode/correct block:
// stream ports, configuration registers, input and result registers.
// Depends on hsec_pkg, hsec_encode and hsec_decode.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------
//  s_       | in        | s_tvalid/s_tready  | data_word, flip_mask
//  m_       | out       | m_tvalid/m_tready  | codeword, code_length, syndrome,
//           |           |                    | range_error, corrected_data
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// After the input transaction the item is held in the input register, then passes the
// encode/decode logic into the result register, from which its result transaction
// is offered on the m_ channel.
// One item per cycle is sustained while m_tready stays high.
// The input register accepts when it is empty or when its item moves into the
// result register in the same cycle; with m_tready low both stages fill and
// s_tready drops.
// Reset (aresetn low, synchronous) empties both stages and restores
// check_bits to 3 and pad_to_byte to 0. Configuration writes are always taken.
module hamming_sec_encode_correct #(
    parameter int DATA_W    = hsec_pkg::DATA_W_DEF,
    parameter int MAX_CHECK = hsec_pkg::MAX_CHECK_DEF,
    localparam int CW_W     = DATA_W + MAX_CHECK,
    localparam int IN_W     = DATA_W + CW_W,
    localparam int IN_PAD_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W    = CW_W + 2 * hsec_pkg::LEN_W + 1 + DATA_W,
    localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: data_word, flip_mask, zero fill.
    input  logic [IN_PAD_W-1:0]             s_tdata,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: codeword, code_length, syndrome, range_error,
    // corrected_data, zero fill.
    output logic [OUT_PAD_W-1:0]            m_tdata,
    // Configuration writes.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hsec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hsec_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = hsec_pkg::LEN_W;
    localparam int CHK_W = hsec_pkg::CHK_W;

    // Configuration registers.
    logic [CHK_W-1:0] check_bits_reg;
    logic [CHK_W-1:0] check_bits_next;
    logic             pad_reg;
    logic             pad_next;
    logic [CHK_W-1:0] check_cnt;

    // Input stage.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [DATA_W-1:0] in_data_reg;
    logic [CW_W-1:0]   in_flip_reg;
    logic              in_ready;
    logic              in_load;

    // Result stage.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CW_W-1:0]   out_code_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic [LEN_W-1:0]  out_syn_reg;
    logic              out_err_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_ready;
    logic              out_load;

    // Datapath between the stages.
    logic [CW_W-1:0]     enc_word;
    hsec_pkg::enc_stat_t enc_stat;
    hsec_pkg::dec_stat_t dec_stat;
    logic [DATA_W-1:0]   dec_data;

    // Configuration write decode.
    assign cfg_ready = 1'b1;

    always_comb begin
        check_bits_next = check_bits_reg;
        pad_next        = pad_reg;
        if (cfg_valid) begin
            unique case (hsec_pkg::cfg_index_t'(cfg_index))
                hsec_pkg::CFG_CHECK_BITS: begin
                    check_bits_next = cfg_data[CHK_W-1:0];
                end
                hsec_pkg::CFG_PAD_TO_BYTE: begin
                    pad_next = cfg_data[0];
                end
                default: begin
                    check_bits_next = check_bits_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_bits_reg <= hsec_pkg::CHECK_RESET;
            pad_reg        <= 1'b0;
        end else begin
            check_bits_reg <= check_bits_next;
            pad_reg        <= pad_next;
        end
    end

    // Check counts above the supported maximum act as the maximum.
    assign check_cnt = (check_bits_reg > CHK_W'(MAX_CHECK)) ? CHK_W'(MAX_CHECK)
                                                            : check_bits_reg;

    // Stage handshakes: each stage frees up when its successor takes it.
    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;
    assign in_load   = s_tvalid && in_ready;
    assign out_load  = in_valid_reg && out_ready;

    always_comb begin
        in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_data_reg <= s_tdata[DATA_W-1:0];
            in_flip_reg <= s_tdata[IN_W-1:DATA_W];
        end
    end

    // Encode, inject and correct between the two registers.
    hsec_encode #(
        .DATA_W    (DATA_W),
        .MAX_CHECK (MAX_CHECK)
    ) u_encode (
        .data_word   (in_data_reg),
        .check_cnt   (check_cnt),
        .pad_to_byte (pad_reg),
        .codeword    (enc_word),
        .stat        (enc_stat)
    );

    hsec_decode #(
        .DATA_W    (DATA_W),
        .MAX_CHECK (MAX_CHECK)
    ) u_decode (
        .codeword       (enc_word),
        .flip_mask      (in_flip_reg),
        .check_cnt      (check_cnt),
        .enc_stat       (enc_stat),
        .stat           (dec_stat),
        .corrected_data (dec_data)
    );

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_code_reg <= enc_word;
            out_len_reg  <= enc_stat.code_len;
            out_syn_reg  <= dec_stat.syndrome;
            out_err_reg  <= dec_stat.range_error;
            out_data_reg <= dec_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_PAD_W'({out_data_reg, out_err_reg, out_syn_reg,
                                  out_len_reg, out_code_reg});

endmodule
